// ===== rtl/core/uodc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ultrasonic obstacle drive controller.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package uodc_pkg;

   localparam int NUM_SENSORS   = 4;
   localparam int HISTORY_DEPTH = 5;
   localparam int FRONT_SENSOR  = 1;

   localparam int SEL_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
   localparam int HPTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   // Field widths fixed by the payload definition
   localparam int MODE_W    = 2;
   localparam int STAMP_W   = 16;
   localparam int FRAME_W   = 10;
   localparam int LINES_W   = 4;
   localparam int HIST_W    = 5;
   localparam int STATE_W   = 2;
   localparam int PRESS_W   = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TICKS    = 1'd1;
   localparam logic [STAMP_W-1:0]   NEAR_THRESHOLD_RST = 16'd110;
   localparam logic [FRAME_W-1:0]   FRAME_TICKS_RST    = 10'd700;

   // Trigger pulse: line high at the first counted tick, low at the second
   localparam logic [FRAME_W-1:0] TRIG_RISE_COUNT = 10'd1;
   localparam logic [FRAME_W-1:0] TRIG_FALL_COUNT = 10'd2;

   // Button press counts that change the drive state
   localparam logic [PRESS_W-1:0] PRESS_START = 2'd1;
   localparam logic [PRESS_W-1:0] PRESS_STOP  = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 2'd0,
      MODE_ECHO   = 2'd1,
      MODE_BUTTON = 2'd2
   } mode_type;

   typedef enum logic [STATE_W-1:0] {
      DRIVE_HALT   = 2'd0,
      DRIVE_READY  = 2'd1,
      DRIVE_MOVING = 2'd2
   } drive_state_type;

   typedef struct packed {
      logic                tick;
      logic                echo;
      logic                button;
   } evt_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [STAMP_W-1:0]  timestamp;
   } req_payload_type;

   typedef struct packed {
      logic [LINES_W-1:0]  trigger_lines;
      logic [LINES_W-1:0]  obstacle_flags;
      logic                front_led;
      logic                motor_enable;
      logic [STATE_W-1:0]  drive_state;
      logic [HIST_W-1:0]   front_history;
   } rsp_payload_type;

endpackage

// ===== rtl/core/uodc_trigger.sv =====
`timescale 1ns / 1ps
// Trigger sequencer: frame counter, per-sensor tick counters, trigger levels.
// Depends on uodc_pkg.
module uodc_trigger (
   input  logic                                clock,
   input  logic                                reset,
   input  uodc_pkg::evt_type                   evt,
   input  logic [uodc_pkg::FRAME_W-1:0]        frame_ticks,
   input  logic [uodc_pkg::SEL_W-1:0]          sel,
   output logic [uodc_pkg::LINES_W-1:0]        trigger_lines
);

   logic [uodc_pkg::FRAME_W-1:0]     frame_ff, frame_in, frame_inc;
   logic [uodc_pkg::FRAME_W-1:0]     cnt_ff [uodc_pkg::NUM_SENSORS];
   logic [uodc_pkg::FRAME_W-1:0]     cnt_in [uodc_pkg::NUM_SENSORS];
   logic [uodc_pkg::NUM_SENSORS-1:0] trig_ff, trig_in;

   always_comb begin
      frame_inc = frame_ff + uodc_pkg::FRAME_W'(1);
      frame_in  = frame_ff;
      trig_in   = trig_ff;
      for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (evt.tick) begin
         frame_in = frame_inc;
         for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
            if (sel == uodc_pkg::SEL_W'(i)) begin
               cnt_in[i] = cnt_ff[i] + uodc_pkg::FRAME_W'(1);
               if (cnt_in[i] == uodc_pkg::TRIG_RISE_COUNT) trig_in[i] = 1'b1;
               if (cnt_in[i] == uodc_pkg::TRIG_FALL_COUNT) trig_in[i] = 1'b0;
            end
         end
         // frame end: restart the frame and every sensor counter
         if (frame_inc == frame_ticks) begin
            frame_in = '0;
            for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
               cnt_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         trig_ff  <= '0;
         for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         frame_ff <= frame_in;
         trig_ff  <= trig_in;
         for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_comb begin
      trigger_lines = '0;
      for (int i = 0; i < uodc_pkg::LINES_W; i++) begin
         if (i < uodc_pkg::NUM_SENSORS) trigger_lines[i] = trig_ff[i];
      end
   end

`ifndef SYNTHESIS
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      evt.tick && (frame_inc == frame_ticks) |=> frame_ff == '0)
      else $error("frame counter did not restart at frame end");
`endif

endmodule

// ===== rtl/core/uodc_echo.sv =====
`timescale 1ns / 1ps
// Echo capture: pulse width, obstacle flags, sensor rotation, front history ring.
// Depends on uodc_pkg.
module uodc_echo (
   input  logic                                clock,
   input  logic                                reset,
   input  uodc_pkg::evt_type                   evt,
   input  logic [uodc_pkg::STAMP_W-1:0]        timestamp,
   input  logic [uodc_pkg::STAMP_W-1:0]        near_threshold,
   output logic [uodc_pkg::SEL_W-1:0]          sel,
   output logic [uodc_pkg::LINES_W-1:0]        obstacle_flags,
   output logic                                front_flag,
   output logic                                front_flag_next,
   output logic [uodc_pkg::HIST_W-1:0]         front_history
);

   logic                               await_ff, await_in;
   logic [uodc_pkg::STAMP_W-1:0]       rise_ff, rise_in;
   logic [uodc_pkg::STAMP_W-1:0]       width;
   logic                               near;
   logic [uodc_pkg::SEL_W-1:0]         sel_ff, sel_in;
   logic [uodc_pkg::NUM_SENSORS-1:0]   obs_ff, obs_in;
   logic [uodc_pkg::HISTORY_DEPTH-1:0] hist_ff, hist_in;
   logic [uodc_pkg::HPTR_W-1:0]        hptr_ff, hptr_in;

   assign width = timestamp - rise_ff;
   assign near  = (width <= near_threshold);

   always_comb begin
      await_in = await_ff;
      rise_in  = rise_ff;
      sel_in   = sel_ff;
      obs_in   = obs_ff;
      hist_in  = hist_ff;
      hptr_in  = hptr_ff;
      if (evt.echo) begin
         if (!await_ff) begin
            rise_in  = timestamp;
            await_in = 1'b1;
         end else begin
            await_in = 1'b0;
            for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
               if (sel_ff == uodc_pkg::SEL_W'(i)) obs_in[i] = near;
            end
            if (int'(sel_ff) == uodc_pkg::FRONT_SENSOR) begin
               for (int k = 0; k < uodc_pkg::HISTORY_DEPTH; k++) begin
                  if (hptr_ff == uodc_pkg::HPTR_W'(k)) hist_in[k] = near;
               end
               hptr_in = (hptr_ff == uodc_pkg::HPTR_W'(uodc_pkg::HISTORY_DEPTH - 1))
                         ? '0 : hptr_ff + uodc_pkg::HPTR_W'(1);
            end
            sel_in = (sel_ff == uodc_pkg::SEL_W'(uodc_pkg::NUM_SENSORS - 1))
                     ? '0 : sel_ff + uodc_pkg::SEL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff <= 1'b0;
         rise_ff  <= '0;
         sel_ff   <= '0;
         obs_ff   <= '0;
         hist_ff  <= '0;
         hptr_ff  <= '0;
      end else begin
         await_ff <= await_in;
         rise_ff  <= rise_in;
         sel_ff   <= sel_in;
         obs_ff   <= obs_in;
         hist_ff  <= hist_in;
         hptr_ff  <= hptr_in;
      end
   end

   assign sel = sel_ff;

   always_comb begin
      obstacle_flags  = '0;
      front_history   = '0;
      front_flag      = 1'b0;
      front_flag_next = 1'b0;
      for (int i = 0; i < uodc_pkg::LINES_W; i++) begin
         if (i < uodc_pkg::NUM_SENSORS) obstacle_flags[i] = obs_ff[i];
      end
      for (int k = 0; k < uodc_pkg::HIST_W; k++) begin
         if (k < uodc_pkg::HISTORY_DEPTH) front_history[k] = hist_ff[k];
      end
      for (int i = 0; i < uodc_pkg::NUM_SENSORS; i++) begin
         if (i == uodc_pkg::FRONT_SENSOR) begin
            front_flag      = obs_ff[i];
            front_flag_next = obs_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_pair_done: assert property (@(posedge clock) disable iff (reset)
      evt.echo && await_ff |=> !await_ff && (sel_ff != $past(sel_ff) ||
      uodc_pkg::NUM_SENSORS == 1))
      else $error("falling capture did not close the measurement");
`endif

endmodule

// ===== rtl/core/uodc_drive.sv =====
`timescale 1ns / 1ps
// Drive state machine stepped by button edges, gated by the front obstacle flag.
// Depends on uodc_pkg.
module uodc_drive (
   input  logic                                clock,
   input  logic                                reset,
   input  uodc_pkg::evt_type                   evt,
   input  logic                                step,
   input  logic                                front_flag_next,
   output logic                                motor_enable,
   output logic [uodc_pkg::STATE_W-1:0]        drive_state
);

   logic [uodc_pkg::PRESS_W-1:0] press_ff, press_in;
   uodc_pkg::drive_state_type    state_ff, state_in, state_btn;
   logic                         motor_ff, motor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= '0;
         state_ff <= uodc_pkg::DRIVE_HALT;
         motor_ff <= 1'b0;
      end else begin
         press_ff <= press_in;
         state_ff <= state_in;
         motor_ff <= motor_in;
      end
   end

   always_comb begin
      press_in  = press_ff;
      state_btn = state_ff;
      if (evt.button) begin
         press_in = press_ff + uodc_pkg::PRESS_W'(1);
         if (press_in == uodc_pkg::PRESS_START) state_btn = uodc_pkg::DRIVE_READY;
         if (press_in == uodc_pkg::PRESS_STOP)  state_btn = uodc_pkg::DRIVE_HALT;
      end
      state_in = state_btn;
      motor_in = motor_ff;
      if (step) begin
         case (state_btn)
            uodc_pkg::DRIVE_READY: begin
               motor_in = !front_flag_next;
               if (!front_flag_next) state_in = uodc_pkg::DRIVE_MOVING;
            end
            uodc_pkg::DRIVE_MOVING: begin
               motor_in = !front_flag_next;
            end
            default: begin
               motor_in = 1'b0;
            end
         endcase
      end
   end

   assign motor_enable = motor_ff;
   assign drive_state  = state_ff;

`ifndef SYNTHESIS
   a_motor_moving: assert property (@(posedge clock) disable iff (reset)
      motor_ff |-> state_ff == uodc_pkg::DRIVE_MOVING)
      else $error("motor enabled outside the moving state");
`endif

endmodule

// ===== rtl/core/ultrasonic_obstacle_drive_controller.sv =====
`timescale 1ns / 1ps
// Top level of the ultrasonic obstacle drive controller.
// Depends on uodc_pkg, uodc_trigger, uodc_echo and uodc_drive.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   req     | in        | req_valid / req_stall  | req_payload_type (mode, timestamp)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_payload_type (state after request)
//   csr     | in        | csr_we, no wait        | csr_index, csr_wdata
//
// One request per cycle sustained while no result stalls; a taken request passes
// the input register, then the state update that also forms the result.
// The result fields are read straight from the state registers, which only move
// when a request passes into the result stage, so a stalled result holds.
// Reset is synchronous and resets all state but the held request payload at once; there is no clearing pass.
// A stalled result blocks the input register, which then stalls req in turn.
module ultrasonic_obstacle_drive_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  uodc_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output uodc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_we,
   input  logic [uodc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [uodc_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [uodc_pkg::STAMP_W-1:0] near_thr_ff, near_thr_in;
   logic [uodc_pkg::FRAME_W-1:0] frame_ticks_ff, frame_ticks_in;

   // Input stage and result stage handshake
   logic                      s1_valid_ff, s1_valid_in;
   uodc_pkg::req_payload_type s1_req_ff, s1_req_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_ready;
   logic                      advance;
   logic                      accept;
   uodc_pkg::evt_type         evt;

   // Block state as seen at the result
   logic [uodc_pkg::SEL_W-1:0]   sel;
   logic [uodc_pkg::LINES_W-1:0] trigger_lines;
   logic [uodc_pkg::LINES_W-1:0] obstacle_flags;
   logic                         front_flag;
   logic                         front_flag_next;
   logic [uodc_pkg::HIST_W-1:0]  front_history;
   logic                         motor_enable;
   logic [uodc_pkg::STATE_W-1:0] drive_state;

   // Write a register by index; indexes past the list are dropped
   always_comb begin
      near_thr_in    = near_thr_ff;
      frame_ticks_in = frame_ticks_ff;
      if (csr_we) begin
         case (csr_index)
            uodc_pkg::CSR_NEAR_THRESHOLD: near_thr_in    = csr_wdata;
            uodc_pkg::CSR_FRAME_TICKS:    frame_ticks_in = csr_wdata[uodc_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         near_thr_ff    <= uodc_pkg::NEAR_THRESHOLD_RST;
         frame_ticks_ff <= uodc_pkg::FRAME_TICKS_RST;
      end else begin
         near_thr_ff    <= near_thr_in;
         frame_ticks_ff <= frame_ticks_in;
      end
   end

   // Result stage frees up when empty or when its result is taken this cycle
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_req_in    = s1_req_ff;
      rsp_valid_in = rsp_valid_ff;
      // drop a taken result, then advance the held request into its place
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_req_in   = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
   end

   // Decode the held request into one event; the unused mode is no event
   always_comb begin
      evt = '0;
      if (advance) begin
         case (s1_req_ff.mode)
            uodc_pkg::MODE_TICK:   evt.tick   = 1'b1;
            uodc_pkg::MODE_ECHO:   evt.echo   = 1'b1;
            uodc_pkg::MODE_BUTTON: evt.button = 1'b1;
            default: ;
         endcase
      end
   end

   uodc_trigger u_trigger (
      .clock         (clock),
      .reset         (reset),
      .evt           (evt),
      .frame_ticks   (frame_ticks_ff),
      .sel           (sel),
      .trigger_lines (trigger_lines)
   );

   uodc_echo u_echo (
      .clock           (clock),
      .reset           (reset),
      .evt             (evt),
      .timestamp       (s1_req_ff.timestamp),
      .near_threshold  (near_thr_ff),
      .sel             (sel),
      .obstacle_flags  (obstacle_flags),
      .front_flag      (front_flag),
      .front_flag_next (front_flag_next),
      .front_history   (front_history)
   );

   // The drive machine runs after every request, whatever its mode
   uodc_drive u_drive (
      .clock           (clock),
      .reset           (reset),
      .evt             (evt),
      .step            (advance),
      .front_flag_next (front_flag_next),
      .motor_enable    (motor_enable),
      .drive_state     (drive_state)
   );

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_payload                = '0;
      rsp_payload.trigger_lines  = trigger_lines;
      rsp_payload.obstacle_flags = obstacle_flags;
      rsp_payload.front_led      = front_flag;
      rsp_payload.motor_enable   = motor_enable;
      rsp_payload.drive_state    = drive_state;
      rsp_payload.front_history  = front_history;
   end

`ifndef SYNTHESIS
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no result");

   a_held_request: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("held request lost or changed");

   a_no_event_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> evt == '0)
      else $error("state moved while a result was stalled");
`endif

endmodule

// ===== dv/ultrasonic_obstacle_drive_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_obstacle_drive_controller.
// Depends on uodc_pkg and the RTL top level; a built-in status predictor checks every result.
module ultrasonic_obstacle_drive_controller_tb;
   import uodc_pkg::*;

   // Mode code that the block must ignore as an event but still report on
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   ultrasonic_obstacle_drive_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Status predictor: own copy of the controller state and its registers
   // ---------------------------------------------------------------------
   logic [STAMP_W-1:0] near_limit;
   logic [FRAME_W-1:0] frame_len;
   logic [FRAME_W-1:0] frame_cnt;
   logic [FRAME_W-1:0] ping_cnt [NUM_SENSORS];
   logic [LINES_W-1:0] trig_lvl;
   logic [SEL_W-1:0] sel;
   logic awaiting_fall;
   logic [STAMP_W-1:0] rise_stamp;
   logic [LINES_W-1:0] obst;
   logic [HIST_W-1:0] ring;
   logic [HPTR_W-1:0] ring_ptr;
   logic [PRESS_W-1:0] presses;
   drive_state_type drive;
   logic motor;

   rsp_payload_type expected_status[$];
   rsp_payload_type want_status;

   // Bookkeeping for the run summary and the verdict
   int error_count = 0;
   int items_sent = 0;
   int results_seen = 0;
   int config_writes = 0;
   int held_off_cycles = 0;
   int tick_count = 0;

   // Pacing controls shared by the sender and the result-side stall process
   bit req_pace = 1'b1;
   bit rsp_pace = 1'b1;
   int hold_ask = 0;
   int hold_left = 0;
   int stall_left = 0;
   int stall_roll;

   task automatic clear_model();
      near_limit = NEAR_THRESHOLD_RST;
      frame_len = FRAME_TICKS_RST;
      frame_cnt = '0;
      foreach (ping_cnt[i]) ping_cnt[i] = '0;
      trig_lvl = '0;
      sel = '0;
      awaiting_fall = 1'b0;
      rise_stamp = '0;
      obst = '0;
      ring = '0;
      ring_ptr = '0;
      presses = '0;
      drive = DRIVE_HALT;
      motor = 1'b0;
   endtask

   // Apply one request to the model and form the status it should report
   task automatic advance_controller(input req_payload_type item, output rsp_payload_type status);
      logic [FRAME_W-1:0] count;
      logic [STAMP_W-1:0] width;
      logic near;
      case (item.mode)
         MODE_TICK: begin
            frame_cnt = frame_cnt + 1'b1;
            count = ping_cnt[sel] + 1'b1;
            ping_cnt[sel] = count;
            if (count == TRIG_RISE_COUNT) trig_lvl[sel] = 1'b1;
            if (count == TRIG_FALL_COUNT) trig_lvl[sel] = 1'b0;
            // frame end restarts the frame and every sensor's pulse counter
            if (frame_cnt == frame_len) begin
               frame_cnt = '0;
               foreach (ping_cnt[i]) ping_cnt[i] = '0;
            end
         end
         MODE_ECHO: begin
            if (!awaiting_fall) begin
               rise_stamp = item.timestamp;
               awaiting_fall = 1'b1;
            end else begin
               width = item.timestamp - rise_stamp;
               near = (width <= near_limit);
               obst[sel] = near;
               if (sel == SEL_W'(FRONT_SENSOR)) begin
                  ring[ring_ptr] = near;
                  ring_ptr = (ring_ptr == HPTR_W'(HISTORY_DEPTH - 1)) ? '0 : ring_ptr + 1'b1;
               end
               sel = (sel == SEL_W'(NUM_SENSORS - 1)) ? '0 : sel + 1'b1;
               awaiting_fall = 1'b0;
            end
         end
         MODE_BUTTON: begin
            presses = presses + 1'b1;
            if (presses == PRESS_START) drive = DRIVE_READY;
            if (presses == PRESS_STOP) drive = DRIVE_HALT;
         end
         default: ;
      endcase
      // drive machine runs after every request, the unused mode included
      case (drive)
         DRIVE_READY: begin
            if (obst[FRONT_SENSOR]) begin
               motor = 1'b0;
            end else begin
               motor = 1'b1;
               drive = DRIVE_MOVING;
            end
         end
         DRIVE_MOVING: motor = !obst[FRONT_SENSOR];
         default: motor = 1'b0;
      endcase
      status.trigger_lines = trig_lvl;
      status.obstacle_flags = obst;
      status.front_led = obst[FRONT_SENSOR];
      status.motor_enable = motor;
      status.drive_state = drive;
      status.front_history = ring;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(bit paced);
      int r;
      if (!paced) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // Widths that sit on, just around, and far from the current threshold
   function automatic logic [STAMP_W-1:0] pick_echo_width();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return near_limit;
         2: return near_limit + 1'b1;
         3: return near_limit - 1'b1;
         4: return '1;
         5: return STAMP_W'($urandom_range(0, 400));
         default: return STAMP_W'($urandom);
      endcase
   endfunction

   // Offer one request, hold it until taken, then record what it should produce
   task automatic send_event(input logic [MODE_W-1:0] mode, input logic [STAMP_W-1:0] stamp);
      req_payload_type item;
      rsp_payload_type outcome;
      int gap;
      item.mode = mode;
      item.timestamp = stamp;
      gap = pick_gap(req_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = item;
      do @(posedge clock); while (req_stall);
      advance_controller(item, outcome);
      expected_status.push_back(outcome);
      items_sent++;
      if (mode == MODE_TICK) tick_count++;
   endtask

   task automatic send_echo_edges(input logic [STAMP_W-1:0] rise, input logic [STAMP_W-1:0] fall);
      send_event(MODE_ECHO, rise);
      send_event(MODE_ECHO, fall);
   endtask

   // Mostly well-formed traffic; lone edges and the unused mode as noise
   task automatic send_random_event(input int tick_pct);
      logic [STAMP_W-1:0] rise;
      int r;
      rise = STAMP_W'($urandom);
      if ($urandom_range(0, 99) < tick_pct) begin
         send_event(MODE_TICK, STAMP_W'($urandom));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) send_echo_edges(rise, rise + pick_echo_width());
         else if (r < 82) send_event(MODE_BUTTON, STAMP_W'($urandom));
         else if (r < 91) send_event(MODE_UNUSED, STAMP_W'($urandom));
         else send_event(MODE_ECHO, rise);
      end
   endtask

   // Drop valid, let every expected result come out, then idle past the latency
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_NEAR_THRESHOLD) near_limit = data;
      else frame_len = data[FRAME_W-1:0];
      config_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, optional long hold, and the checker
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      // pick up a long hold asked for by a test
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (!rsp_pace) begin
         rsp_stall = 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 70) begin
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b1;
            stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(6, 30);
         end
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall) held_off_cycles++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               report_mismatch("result with no request pending", 32'(rsp_payload), 0);
            end else begin
               want_status = expected_status.pop_front();
               if (rsp_payload.trigger_lines !== want_status.trigger_lines)
                  report_mismatch("trigger_lines", 32'(rsp_payload.trigger_lines),
                                  32'(want_status.trigger_lines));
               if (rsp_payload.obstacle_flags !== want_status.obstacle_flags)
                  report_mismatch("obstacle_flags", 32'(rsp_payload.obstacle_flags),
                                  32'(want_status.obstacle_flags));
               if (rsp_payload.front_led !== want_status.front_led)
                  report_mismatch("front_led", 32'(rsp_payload.front_led),
                                  32'(want_status.front_led));
               if (rsp_payload.motor_enable !== want_status.motor_enable)
                  report_mismatch("motor_enable", 32'(rsp_payload.motor_enable),
                                  32'(want_status.motor_enable));
               if (rsp_payload.drive_state !== want_status.drive_state)
                  report_mismatch("drive_state", 32'(rsp_payload.drive_state),
                                  32'(want_status.drive_state));
               if (rsp_payload.front_history !== want_status.front_history)
                  report_mismatch("front_history", 32'(rsp_payload.front_history),
                                  32'(want_status.front_history));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Walk every sensor at reset settings: ignored mode, start button,
   // trigger pulse rise and fall, width equal to threshold, zero width,
   // wrapped stamps, widest width, and the full button cycle.
   task automatic test_directed_basics();
      send_event(MODE_UNUSED, 16'hFFFF);
      send_event(MODE_BUTTON, 16'h0000);
      send_event(MODE_TICK, 16'hFFFF);
      send_event(MODE_TICK, 16'h0000);
      send_echo_edges(16'hFFFF, 16'h006D);   // back: width 110 across stamp wrap
      send_echo_edges(16'h1234, 16'h1234);   // front: zero width halts the motor
      send_event(MODE_TICK, 16'h5555);
      send_echo_edges(16'd100, 16'd211);     // left: one above threshold
      send_echo_edges(16'h0000, 16'hFFFF);   // right: widest width
      send_echo_edges(16'd7, 16'd7);
      send_echo_edges(16'd5, 16'd205);       // front clear again, motor back on
      repeat (4) send_event(MODE_BUTTON, 16'hAAAA);   // -, halt, wrap, ready
      wait_for_drain();
   endtask

   task automatic test_threshold_extremes();
      write_config(CSR_NEAR_THRESHOLD, 16'd0);
      write_config(CSR_FRAME_TICKS, 16'd1023);
      send_echo_edges(16'h8000, 16'h8000);
      send_echo_edges(16'h8000, 16'h8001);
      repeat (3) send_event(MODE_TICK, STAMP_W'($urandom));
      wait_for_drain();
      write_config(CSR_NEAR_THRESHOLD, 16'hFFFF);
      send_echo_edges(16'h0001, 16'h0000);
      send_echo_edges(STAMP_W'($urandom), STAMP_W'($urandom));
      wait_for_drain();
   endtask

   // Hold results off for a long stretch while requests keep coming
   task automatic test_backpressure();
      int target;
      req_pace = 1'b0;
      rsp_pace = 1'b0;
      hold_ask = 60;
      target = items_sent + 40;
      while (items_sent < target) send_random_event(40);
      wait_for_drain();
      req_pace = 1'b1;
      rsp_pace = 1'b1;
   endtask

   // Lower the frame end below the running count so the counter wraps through
   // its top value before restarting; the sensor counters keep counting meanwhile.
   task automatic test_frame_wrap();
      int target;
      write_config(CSR_FRAME_TICKS, 16'd40);
      target = tick_count + 30;
      while (tick_count < target) send_random_event(85);
      wait_for_drain();
      write_config(CSR_FRAME_TICKS, 16'd3);
      target = tick_count + 1040;
      while (tick_count < target) send_random_event(95);
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      int target;
      for (int phase = 0; phase < 6; phase++) begin
         // sender waits here until every expected result is in
         wait_for_drain();
         case ($urandom_range(0, 3))
            0: write_config(CSR_NEAR_THRESHOLD, 16'd0);
            1: write_config(CSR_NEAR_THRESHOLD, 16'hFFFF);
            2: write_config(CSR_NEAR_THRESHOLD, CSR_DAT_W'($urandom_range(0, 400)));
            default: write_config(CSR_NEAR_THRESHOLD, CSR_DAT_W'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0: write_config(CSR_FRAME_TICKS, 16'd3);
            1: write_config(CSR_FRAME_TICKS, 16'd1023);
            2: write_config(CSR_FRAME_TICKS, CSR_DAT_W'($urandom_range(3, 40)));
            default: write_config(CSR_FRAME_TICKS, CSR_DAT_W'($urandom_range(3, 1023)));
         endcase
         // leave some phases without gaps on one side
         req_pace = (phase % 3 != 2);
         rsp_pace = (phase % 4 != 3);
         target = items_sent + 20;
         while (items_sent < target) send_random_event(40);
      end
      wait_for_drain();
      req_pace = 1'b1;
      rsp_pace = 1'b1;
   endtask

   initial begin
      clear_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_basics();
      test_threshold_extremes();
      test_backpressure();
      test_frame_wrap();
      test_random_traffic();
      wait_for_drain();
      $display("Run covered %0d requests (%0d ticks) and %0d checked results",
               items_sent, tick_count, results_seen);
      $display("over %0d register writes; requests were held off for %0d cycles in total.",
               config_writes, held_off_cycles);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Timeout with %0d results still pending", expected_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/uodc_pkg.sv
rtl/core/uodc_trigger.sv
rtl/core/uodc_echo.sv
rtl/core/uodc_drive.sv
rtl/core/ultrasonic_obstacle_drive_controller.sv
dv/ultrasonic_obstacle_drive_controller_tb.sv
